@@ rtl/euler_to_quaternion_core_defines.svh @@
// Assertion macros for the Euler-to-quaternion core.
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define ETQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ETQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ETQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`else

`define ETQ_ASSERT(lbl, prop, msg)
`define ETQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define ETQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/etq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package etq_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NSTAGE = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    localparam int ANGLE_W = 16;
    localparam int QUAT_W  = 16;
    localparam int ZW      = 34;
    localparam int CW      = 32;
    localparam int PW      = 64;
    localparam int SW      = PW + 1;
    localparam int QW      = SW - 46;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [QW-1:0] Q14_ONE     = 19'sd16384;

    typedef logic signed [CW-1:0] trig_t;
    typedef logic signed [QUAT_W-1:0] quat_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] a;
        unique case (idx)
            0:  a = 34'sd843314856;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043836;
            3:  a = 34'sd133525158;
            4:  a = 34'sd67021686;
            5:  a = 34'sd33543515;
            6:  a = 34'sd16775850;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194282;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048575;
            11: a = 34'sd524287;
            12: a = 34'sd262143;
            13: a = 34'sd131071;
            14: a = 34'sd65535;
            15: a = 34'sd32767;
            16: a = 34'sd16383;
            17: a = 34'sd8191;
            18: a = 34'sd4095;
            19: a = 34'sd2047;
            20: a = 34'sd1023;
            21: a = 34'sd511;
            22: a = 34'sd255;
            23: a = 34'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

@@ rtl/etq_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
module etq_cordic (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [etq_pkg::ANGLE_W-1:0]  angle,
    output logic                                     out_valid,
    output etq_pkg::trig_t                           cos_o,
    output etq_pkg::trig_t                           sin_o
);
    import etq_pkg::*;

    logic signed [ZW-1:0] x_reg [0:NSTAGE];
    logic signed [ZW-1:0] y_reg [0:NSTAGE];
    logic signed [ZW-1:0] z_reg [0:NSTAGE];
    logic                 neg_reg [0:NSTAGE];
    logic                 v_reg [0:NSTAGE];

    logic signed [ZW-1:0] h;
    logic signed [ZW-1:0] z_next;
    logic                 neg_next;
    logic                 ov_reg;
    trig_t                cos_reg;
    trig_t                sin_reg;

    // half angle in Q2.30, folded into [-pi/2, pi/2]
    always_comb
    begin
        h = {{(ZW-ANGLE_W-16){angle[ANGLE_W-1]}}, angle, 16'd0};
        priority if (h > HALF_PI_Q30)
        begin
            z_next   = h - PI_Q30;
            neg_next = 1'b1;
        end
        else if (h < -HALF_PI_Q30)
        begin
            z_next   = h + PI_Q30;
            neg_next = 1'b1;
        end
        else
        begin
            z_next   = h;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= v_reg[NSTAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[NSTAGE] ? CW'(-x_reg[NSTAGE]) : CW'(x_reg[NSTAGE]);
            sin_reg <= neg_reg[NSTAGE] ? CW'(-y_reg[NSTAGE]) : CW'(y_reg[NSTAGE]);
        end
    end

    assign out_valid = ov_reg;
    assign cos_o     = cos_reg;
    assign sin_o     = sin_reg;

    // z_reg[NSTAGE] is the residual angle; not needed downstream
    logic unused_z;
    assign unused_z = ^z_reg[NSTAGE];

endmodule
`default_nettype wire

@@ rtl/etq_quat.sv @@
`timescale 1ns / 1ps
`default_nettype none
module etq_quat (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire etq_pkg::trig_t  cr,
    input  wire etq_pkg::trig_t  sr,
    input  wire etq_pkg::trig_t  cp,
    input  wire etq_pkg::trig_t  sp,
    input  wire etq_pkg::trig_t  cy,
    input  wire etq_pkg::trig_t  sy,
    output logic                 out_valid,
    output etq_pkg::quat_t       quat_w,
    output etq_pkg::quat_t       quat_x,
    output etq_pkg::quat_t       quat_y,
    output etq_pkg::quat_t       quat_z
);
    import etq_pkg::*;

    function automatic trig_t round30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + (64'sd1 <<< 29)) >>> 30;
        return CW'(t);
    endfunction

    function automatic quat_t to_q14(input logic signed [PW-1:0] a,
                                     input logic signed [PW-1:0] b,
                                     input logic                 sub);
        logic signed [SW-1:0] s;
        logic signed [QW-1:0] q;
        quat_t                r;
        s = sub ? ({a[PW-1], a} - {b[PW-1], b}) : ({a[PW-1], a} + {b[PW-1], b});
        s = s + (65'sd1 <<< 45);
        q = QW'(s >>> 46);
        priority if (q > Q14_ONE)
            r = QUAT_W'(Q14_ONE);
        else if (q < -Q14_ONE)
            r = QUAT_W'(-Q14_ONE);
        else
            r = QUAT_W'(q);
        return r;
    endfunction

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [PW-1:0] cycp_reg, sysp_reg, cysp_reg, sycp_reg;
    trig_t                cr1_reg, sr1_reg;
    logic signed [PW-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [PW-1:0] t4_reg, t5_reg, t6_reg, t7_reg;
    quat_t                w_reg, x_reg, y_reg, z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycp_reg <= cy * cp;
            sysp_reg <= sy * sp;
            cysp_reg <= cy * sp;
            sycp_reg <= sy * cp;
            cr1_reg  <= cr;
            sr1_reg  <= sr;

            t0_reg <= round30(cycp_reg) * cr1_reg;
            t1_reg <= round30(sysp_reg) * sr1_reg;
            t2_reg <= round30(cycp_reg) * sr1_reg;
            t3_reg <= round30(sysp_reg) * cr1_reg;
            t4_reg <= round30(sycp_reg) * sr1_reg;
            t5_reg <= round30(cysp_reg) * cr1_reg;
            t6_reg <= round30(sycp_reg) * cr1_reg;
            t7_reg <= round30(cysp_reg) * sr1_reg;

            w_reg <= to_q14(t0_reg, t1_reg, 1'b0);
            x_reg <= to_q14(t2_reg, t3_reg, 1'b1);
            y_reg <= to_q14(t4_reg, t5_reg, 1'b0);
            z_reg <= to_q14(t6_reg, t7_reg, 1'b1);
        end
    end

    assign out_valid = v3_reg;
    assign quat_w    = w_reg;
    assign quat_x    = x_reg;
    assign quat_y    = y_reg;
    assign quat_z    = z_reg;

endmodule
`default_nettype wire

@@ rtl/euler_to_quaternion_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Fields (low bit up)
// s_axis   in   tdata: roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
// m_axis   out  tdata: quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
//
// One beat in and one beat out per cycle while the output is not stalled.
// Stages: fold, CORDIC stages, sign fix, two multiply stages, round/saturate.
// All stages advance together; a stalled output freezes the whole pipeline.
// Asynchronous active-low reset clears valid bits only.
module euler_to_quaternion_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // quat_w, quat_x, quat_y, quat_z
);
    import etq_pkg::*;
    `include "euler_to_quaternion_core_defines.svh"

    logic  en;
    logic  vr, vp, vy;
    trig_t cr, sr, cp, sp, cy, sy;
    quat_t qw, qx, qy, qz;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    etq_cordic u_roll (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .angle(s_tdata[15:0]), .out_valid(vr), .cos_o(cr), .sin_o(sr)
    );

    etq_cordic u_pitch (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .angle(s_tdata[31:16]), .out_valid(vp), .cos_o(cp), .sin_o(sp)
    );

    etq_cordic u_yaw (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .angle(s_tdata[47:32]), .out_valid(vy), .cos_o(cy), .sin_o(sy)
    );

    etq_quat u_quat (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vr && vp && vy),
        .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
        .out_valid(m_tvalid),
        .quat_w(qw), .quat_x(qx), .quat_y(qy), .quat_z(qz)
    );

    assign m_tdata = {qz, qy, qx, qw};

    `ETQ_ASSERT(a_lanes_aligned, (vr == vp) && (vp == vy), "CORDIC lanes out of step")
    `ETQ_ASSERT_IMPL(a_w_sat, m_tvalid, (qw <= 16'sd16384) && (qw >= -16'sd16384),
        "quat_w beyond saturation limit")
    `ETQ_ASSERT_IMPL(a_x_sat, m_tvalid, (qx <= 16'sd16384) && (qx >= -16'sd16384),
        "quat_x beyond saturation limit")
    `ETQ_ASSERT_NEXT(a_reset_empty, !rst_n, !m_tvalid, "output valid right after reset")

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import etq_pkg::*;

    localparam int LATENCY = CORDIC_STAGES + 5;
    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM = 1150;

    localparam longint ATAN_TAB [24] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047,
        1023, 511, 255, 127
    };

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } quat_beat_t;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void half_trig(logic signed [15:0] ang, output longint c,
                                      output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * 65536;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1;
        end
        else if (z < -1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_TAB[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_TAB[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint prod3(longint a, longint b, longint c);
        return floor_shr(a * b + (longint'(1) << 29), 30) * c;
    endfunction

    function automatic logic signed [15:0] round_sat(longint v);
        longint r;
        r = floor_shr(v + (longint'(1) << 45), 46);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic quat_beat_t euler_to_quat(logic [47:0] d);
        longint cr, sr, cp, sp, cy, sy;
        quat_beat_t q;
        half_trig(d[15:0], cr, sr);
        half_trig(d[31:16], cp, sp);
        half_trig(d[47:32], cy, sy);
        q.w = round_sat(prod3(cy, cp, cr) + prod3(sy, sp, sr));
        q.x = round_sat(prod3(cy, cp, sr) - prod3(sy, sp, cr));
        q.y = round_sat(prod3(sy, cp, sr) + prod3(cy, sp, cr));
        q.z = round_sat(prod3(sy, cp, cr) - prod3(cy, sp, sr));
        return q;
    endfunction

    int errors = 0;

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class quat_scoreboard;
        quat_beat_t pending_quats[$];

        function void note_angles(logic [47:0] d);
            pending_quats.push_back(euler_to_quat(d));
        endfunction

        task check_quat(logic [63:0] d);
            quat_beat_t got, want;
            got = d;
            if (pending_quats.size() == 0)
            begin
                report("unexpected beat w", got.w, 0);
                return;
            end
            want = pending_quats.pop_front();
            if (got.w !== want.w) report("quat_w", got.w, want.w);
            if (got.x !== want.x) report("quat_x", got.x, want.x);
            if (got.y !== want.y) report("quat_y", got.y, want.y);
            if (got.z !== want.z) report("quat_z", got.z, want.z);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [63:0] m_tdata;

    quat_scoreboard sb = new();
    bit hold_output = 0;
    bit sink_idle = 0;
    int quiet_cycles = 0;

    euler_to_quaternion_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_angles(s_tdata);
        if (m_tvalid && m_tready)
            sb.check_quat(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: random stalls, or a long hold-off while hold_output is set
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                m_tready <= 0;
                repeat (300) @(posedge clk);
                hold_output = 0;
            end
            if (sink_idle || $urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            if (gap > 0)
            begin
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_angles(logic signed [15:0] r, logic signed [15:0] p,
                               logic signed [15:0] y, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {y, p, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 51472) - 25736;
            2: return $urandom_range(0, 25736) - 12868;
            3: return $urandom_range(0, 40) - 20;
            4: return (($urandom_range(0, 1)) ? 16'sd12868 : -16'sd12868)
                      + $urandom_range(0, 6) - 3;
            default: return $urandom_range(0, 13000) - 6500;
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.pending_quats.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [15:0] edges [10];
        int gap;
        edges = '{16'sh0000, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                  16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd6434};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int i = 0; i < 10; i++)
            send_angles(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10], 0);
        send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_angles(16'sd25736, 16'sh0000, 16'sh0000, 0);
        send_angles(16'sh0000, 16'sd25736, 16'sh0000, 2);
        send_angles(16'sh0000, 16'sh0000, 16'sd25736, 0);
        send_angles(16'sd12869, -16'sd12869, 16'sd12867, 0);
        send_angles(16'shAAAA, 16'sh5555, 16'shAAAA, 0);
        send_angles(16'sh5555, 16'shAAAA, 16'sh5555, 0);

        // sender pauses until everything is out
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 300)
                hold_output = 1;
            if (i == 700)
                wait_drained();
            sink_idle = (i >= 850 && i < 950);
            if (hold_output || (i >= 500 && i < 600) || sink_idle)
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            send_angles(rand_angle(), rand_angle(), rand_angle(), gap);
        end
        s_tvalid <= 0;
        while (sb.pending_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ euler_to_quaternion_core.f @@
+incdir+rtl
rtl/etq_pkg.sv
rtl/etq_cordic.sv
rtl/etq_quat.sv
rtl/euler_to_quaternion_core.sv
sim/testbench.sv
